// ===== src/chi_pkg.sv =====
// Shared widths, constants and control structs for the cubic Hermite joint interpolator.
// No dependencies; chi_if and the top level use this package, chi_mul does not.
package chi_pkg;

    localparam int W_TIME  = 26;          // elapsed and span, microseconds
    localparam int W_JOINT = 28;          // positions and velocities
    localparam int W_POS   = 32;          // result position
    localparam int W_SCALE = 20;
    localparam logic [W_SCALE-1:0] SCALE_PER_SECOND = 20'd1000000;

    localparam int W_DEN = 3 * W_TIME + W_SCALE;   // 1e6 * S^3
    localparam int W_TOT = 136;                    // signed numerator a*D + N
    localparam int N_Q   = 33;                     // quotient bits kept

    typedef struct packed {
        logic zs;
        logic a_neg;
        logic dp_neg;
        logic c_neg;
    } t_flags;

    typedef struct packed {
        t_flags                     flags;
        logic signed [W_JOINT-1:0]  a;
        logic [W_JOINT-1:0]         am;
    } t_ctl;

    typedef struct packed {
        logic                       zs;
        logic                       neg;
        logic                       big;
        logic signed [W_JOINT-1:0]  a;
    } t_dc;

endpackage

// ===== src/chi_if.sv =====
// Request channels of the interpolator: segment requests in, positions out.
// Depends on chi_pkg for field widths.
interface chi_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [chi_pkg::W_TIME-1:0]                  elapsed_us;
    logic [chi_pkg::W_TIME-1:0]                  span_us;
    logic signed [chi_pkg::W_JOINT-1:0]          start_position;
    logic signed [chi_pkg::W_JOINT-1:0]          final_position;
    logic signed [chi_pkg::W_JOINT-1:0]          start_velocity;
    logic signed [chi_pkg::W_JOINT-1:0]          final_velocity;

    modport source (output valid, elapsed_us, span_us, start_position, final_position,
                    start_velocity, final_velocity, input ready);
    modport sink   (input valid, elapsed_us, span_us, start_position, final_position,
                    start_velocity, final_velocity, output ready);
endinterface

interface chi_out_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [chi_pkg::W_POS-1:0]            position_out;
    logic                                        saturated;

    modport source (output valid, position_out, saturated, input ready);
    modport sink   (input valid, position_out, saturated, output ready);
endinterface

// ===== src/cubic_hermite_joint_interpolator_unit.sv =====
// Top level of the cubic Hermite joint interpolator: operand prep, limb
// multipliers (chi_mul), signed sum, restoring divider stages and saturation.
// Depends on chi_pkg, chi_if and chi_mul.
//
//  channel  | dir | handshake    | payload
//  i_in     | in  | valid/ready  | elapsed_us, span_us, start/final position, velocity
//  o_out    | out | valid/ready  | position_out, saturated
//
// One request per cycle unless the output stalls. Stages: 3 prep, 3 x 2 multiply,
// sum, abs, 33 divider steps, output register. The divider chain sets the depth.
// Reset clears the valid bits only. A stall at the output freezes every stage;
// i_in.ready is low during reset and while a result waits and o_out.ready is low.
module cubic_hermite_joint_interpolator_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chi_in_if.sink    i_in,
    chi_out_if.source o_out
);
    import chi_pkg::*;

    localparam int NV = 45;

    logic          en;
    logic [NV-1:0] r_vld;

    assign en         = !r_vld[NV-1] || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_in.valid};
        end
    end

    // stage 1: clamp, remaining time, position delta, 3S - 2e
    logic [W_TIME-1:0]         n1_e;
    logic [W_TIME-1:0]         r1_e, r1_r, r1_s;
    logic signed [W_JOINT:0]   r1_dp;
    logic [W_JOINT-1:0]        r1_w;
    logic signed [W_JOINT-1:0] r1_a, r1_b, r1_v1;
    logic                      r1_zs;

    assign n1_e = (i_in.elapsed_us > i_in.span_us) ? i_in.span_us : i_in.elapsed_us;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e  <= n1_e;
            r1_r  <= i_in.span_us - n1_e;
            r1_s  <= i_in.span_us;
            r1_dp <= {i_in.final_position[W_JOINT-1], i_in.final_position}
                   - {i_in.start_position[W_JOINT-1], i_in.start_position};
            r1_w  <= ({2'b00, i_in.span_us} << 1) + {2'b00, i_in.span_us}
                   - {1'b0, n1_e, 1'b0};
            r1_a  <= i_in.start_position;
            r1_b  <= i_in.start_velocity;
            r1_v1 <= i_in.final_velocity;
            r1_zs <= (i_in.span_us == '0);
        end
    end

    // stage 2: narrow products
    logic [W_JOINT-1:0]               n2_dpm;
    logic [2*W_TIME-1:0]              r2_ss;
    logic [W_JOINT+W_SCALE-1:0]       r2_m1;
    logic signed [W_JOINT+W_TIME:0]   r2_c1, r2_c2;
    logic [W_TIME-1:0]                r2_e, r2_r, r2_s;
    logic [W_JOINT-1:0]               r2_w;
    t_ctl                             r2_ctl;

    assign n2_dpm = r1_dp[W_JOINT] ? W_JOINT'(-r1_dp) : W_JOINT'(r1_dp);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ss <= r1_s * r1_s;
            r2_m1 <= n2_dpm * SCALE_PER_SECOND;
            r2_c1 <= r1_b * $signed({1'b0, r1_r});
            r2_c2 <= r1_v1 * $signed({1'b0, r1_e});
            r2_e  <= r1_e;
            r2_r  <= r1_r;
            r2_s  <= r1_s;
            r2_w  <= r1_w;
            r2_ctl.flags.zs     <= r1_zs;
            r2_ctl.flags.a_neg  <= r1_a[W_JOINT-1];
            r2_ctl.flags.dp_neg <= r1_dp[W_JOINT];
            r2_ctl.flags.c_neg  <= 1'b0;
            r2_ctl.a            <= r1_a;
            r2_ctl.am           <= r1_a[W_JOINT-1] ? W_JOINT'(-r1_a) : W_JOINT'(r1_a);
        end
    end

    // stage 3: velocity term b*r - v1*e
    logic signed [W_JOINT+W_TIME:0] n3_c;
    t_ctl                           n3_ctl;
    logic [W_JOINT+W_TIME-1:0]      r3_cm;
    logic [2*W_TIME-1:0]            r3_ss;
    logic [W_JOINT+W_SCALE-1:0]     r3_m1;
    logic [W_TIME-1:0]              r3_e, r3_r, r3_s;
    logic [W_JOINT-1:0]             r3_w;
    t_ctl                           r3_ctl;

    assign n3_c = r2_c1 - r2_c2;

    always_comb begin
        n3_ctl             = r2_ctl;
        n3_ctl.flags.c_neg = n3_c[W_JOINT+W_TIME];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cm  <= n3_c[W_JOINT+W_TIME] ? (W_JOINT+W_TIME)'(-n3_c)
                                           : (W_JOINT+W_TIME)'(n3_c);
            r3_ss  <= r2_ss;
            r3_m1  <= r2_m1;
            r3_e   <= r2_e;
            r3_r   <= r2_r;
            r3_s   <= r2_s;
            r3_w   <= r2_w;
            r3_ctl <= n3_ctl;
        end
    end

    // multiply phase 1: S^3, dp*1e6*w, |c|*S
    localparam int W_S3 = 3 * W_TIME;
    localparam int W_M2 = W_JOINT + W_SCALE + W_JOINT;
    localparam int W_X1 = W_JOINT + W_TIME + W_TIME;

    logic [W_S3-1:0]   p1_s3;
    logic [W_M2-1:0]   p1_m2;
    logic [W_X1-1:0]   p1_x1;
    t_ctl              p1_ctl;
    logic [W_TIME-1:0] p1_e, p1_r;

    chi_mul #(.WA(2*W_TIME), .WB(W_TIME), .WS($bits(t_ctl))) u_mul_s3 (
        .i_clk(i_clk), .i_en(en), .i_a(r3_ss), .i_b(r3_s), .i_side(r3_ctl),
        .o_p(p1_s3), .o_side(p1_ctl));
    chi_mul #(.WA(W_JOINT+W_SCALE), .WB(W_JOINT), .WS(W_TIME)) u_mul_m2 (
        .i_clk(i_clk), .i_en(en), .i_a(r3_m1), .i_b(r3_w), .i_side(r3_e),
        .o_p(p1_m2), .o_side(p1_e));
    chi_mul #(.WA(W_JOINT+W_TIME), .WB(W_TIME), .WS(W_TIME)) u_mul_x1 (
        .i_clk(i_clk), .i_en(en), .i_a(r3_cm), .i_b(r3_s), .i_side(r3_r),
        .o_p(p1_x1), .o_side(p1_r));

    // multiply phase 2: denominator, *e, *e
    localparam int W_M3 = W_M2 + W_TIME;
    localparam int W_X2 = W_X1 + W_TIME;

    logic [W_DEN-1:0]  p2_den;
    logic [W_M3-1:0]   p2_m3;
    logic [W_X2-1:0]   p2_x2;
    t_ctl              p2_ctl;
    logic [W_TIME-1:0] p2_e, p2_r;

    chi_mul #(.WA(W_S3), .WB(W_SCALE), .WS($bits(t_ctl))) u_mul_den (
        .i_clk(i_clk), .i_en(en), .i_a(p1_s3), .i_b(SCALE_PER_SECOND), .i_side(p1_ctl),
        .o_p(p2_den), .o_side(p2_ctl));
    chi_mul #(.WA(W_M2), .WB(W_TIME), .WS(W_TIME)) u_mul_m3 (
        .i_clk(i_clk), .i_en(en), .i_a(p1_m2), .i_b(p1_e), .i_side(p1_e),
        .o_p(p2_m3), .o_side(p2_e));
    chi_mul #(.WA(W_X1), .WB(W_TIME), .WS(W_TIME)) u_mul_x2 (
        .i_clk(i_clk), .i_en(en), .i_a(p1_x1), .i_b(p1_e), .i_side(p1_r),
        .o_p(p2_x2), .o_side(p2_r));

    // multiply phase 3: a*D, *e, *r
    localparam int W_T0 = W_DEN + W_JOINT;
    localparam int W_M4 = W_M3 + W_TIME;
    localparam int W_X3 = W_X2 + W_TIME;

    logic [W_T0-1:0]           p3_t0;
    logic [W_M4-1:0]           p3_m4;
    logic [W_X3-1:0]           p3_x3;
    t_flags                    p3_flags;
    logic [W_DEN-1:0]          p3_den;
    logic signed [W_JOINT-1:0] p3_a;

    chi_mul #(.WA(W_DEN), .WB(W_JOINT), .WS($bits(t_flags))) u_mul_t0 (
        .i_clk(i_clk), .i_en(en), .i_a(p2_den), .i_b(p2_ctl.am), .i_side(p2_ctl.flags),
        .o_p(p3_t0), .o_side(p3_flags));
    chi_mul #(.WA(W_M3), .WB(W_TIME), .WS(W_DEN)) u_mul_m4 (
        .i_clk(i_clk), .i_en(en), .i_a(p2_m3), .i_b(p2_e), .i_side(p2_den),
        .o_p(p3_m4), .o_side(p3_den));
    chi_mul #(.WA(W_X2), .WB(W_TIME), .WS(W_JOINT)) u_mul_x3 (
        .i_clk(i_clk), .i_en(en), .i_a(p2_x2), .i_b(p2_r), .i_side(p2_ctl.a),
        .o_p(p3_x3), .o_side(p3_a));

    // signed sum of the three terms
    logic [W_TOT-1:0]          n_t0, n_t1, n_t2;
    logic [W_TOT-1:0]          r_tot;
    logic [W_DEN-1:0]          r_sden;
    logic                      r_szs;
    logic signed [W_JOINT-1:0] r_sa;

    assign n_t0 = p3_flags.a_neg  ? -W_TOT'(p3_t0) : W_TOT'(p3_t0);
    assign n_t1 = p3_flags.dp_neg ? -W_TOT'(p3_m4) : W_TOT'(p3_m4);
    assign n_t2 = p3_flags.c_neg  ? -W_TOT'(p3_x3) : W_TOT'(p3_x3);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tot  <= n_t0 + n_t1 + n_t2;
            r_sden <= p3_den;
            r_szs  <= p3_flags.zs;
            r_sa   <= p3_a;
        end
    end

    // magnitude, then one restoring step per stage
    logic [W_TOT-1:0] r_rem [0:N_Q-1];
    logic [W_DEN-1:0] r_den [0:N_Q-1];
    logic [N_Q-1:0]   r_q   [0:N_Q];
    t_dc              r_dc  [0:N_Q];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]     <= r_tot[W_TOT-1] ? -r_tot : r_tot;
            r_den[0]     <= r_sden;
            r_q[0]       <= '0;
            r_dc[0].zs   <= r_szs;
            r_dc[0].neg  <= r_tot[W_TOT-1];
            r_dc[0].big  <= 1'b0;
            r_dc[0].a    <= r_sa;
        end
    end

    for (genvar j = 0; j < N_Q; j++) begin : g_div
        localparam int K = N_Q - 1 - j;
        logic [W_TOT-1:0] dsh;
        logic [W_TOT:0]   diff;
        logic             take;
        t_dc              n_dc;

        assign dsh  = W_TOT'(r_den[j]) << K;
        assign diff = {1'b0, r_rem[j]} - {1'b0, dsh};
        assign take = !diff[W_TOT];

        always_comb begin
            n_dc = r_dc[j];
            // first step also flags a quotient that overflows the kept bits
            if (j == 0) begin
                n_dc.big = (r_rem[j] >= (W_TOT'(r_den[j]) << N_Q));
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q[j+1]   <= {r_q[j][N_Q-2:0], take};
                r_dc[j+1]  <= n_dc;
            end
        end

        // the last step needs no remainder or divisor after it
        if (j < N_Q - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[j+1] <= take ? diff[W_TOT-1:0] : r_rem[j];
                    r_den[j+1] <= r_den[j];
                end
            end
        end
    end

    // saturation and output register
    localparam logic [N_Q-1:0] Q_POS_MAX = N_Q'(32'h7FFF_FFFF);
    localparam logic [N_Q-1:0] Q_NEG_MAX = N_Q'(32'h8000_0000);

    logic [W_POS-1:0] r_pos;
    logic             r_sat;
    t_dc              dcf;
    logic [N_Q-1:0]   qf;

    assign dcf = r_dc[N_Q];
    assign qf  = r_q[N_Q];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (dcf.zs) begin
                r_pos <= W_POS'(dcf.a);
                r_sat <= 1'b0;
            end else if (!dcf.neg) begin
                if (dcf.big || qf > Q_POS_MAX) begin
                    r_pos <= 32'h7FFF_FFFF;
                    r_sat <= 1'b1;
                end else begin
                    r_pos <= qf[W_POS-1:0];
                    r_sat <= 1'b0;
                end
            end else begin
                if (dcf.big || qf > Q_NEG_MAX) begin
                    r_pos <= 32'h8000_0000;
                    r_sat <= 1'b1;
                end else begin
                    r_pos <= -qf[W_POS-1:0];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid        = r_vld[NV-1];
    assign o_out.position_out = r_pos;
    assign o_out.saturated    = r_sat;
endmodule

// ===== src/chi_mul.sv =====
// Two-stage unsigned multiplier: A is cut into 32-bit limbs, limb products are
// registered, then summed. Carries a sideband vector alongside. No dependencies.
module chi_mul #(
    parameter int WA = 64,
    parameter int WB = 28,
    parameter int WS = 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    input  logic [WS-1:0]      i_side,
    output logic [WA+WB-1:0]   o_p,
    output logic [WS-1:0]      o_side
);
    localparam int NL = (WA + 31) / 32;
    localparam int WX = NL * 32 + WB;

    logic [NL*32-1:0] a_ext;
    logic [31+WB:0]   r_pp [0:NL-1];
    logic [WS-1:0]    r_side1;
    logic [WX-1:0]    n_p;
    logic [WA+WB-1:0] r_p;
    logic [WS-1:0]    r_side2;

    assign a_ext = (NL*32)'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NL; i++) begin
                r_pp[i] <= a_ext[32*i +: 32] * i_b;
            end
            r_side1 <= i_side;
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NL; i++) begin
            n_p = n_p + (WX'(r_pp[i]) << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= n_p[WA+WB-1:0];
            r_side2 <= r_side1;
        end
    end

    assign o_p    = r_p;
    assign o_side = r_side2;
endmodule
